// ===== rtl/tkac_pkg.sv =====
package tkac_pkg;

    localparam int LOGIT_W    = 48;
    localparam int TGT_W      = 12;
    localparam int VOCAB_W    = 13;
    localparam int TOPK_W     = 5;
    localparam int CNT_W      = 16;
    localparam int ACC_W      = 17;
    localparam int VOCAB_MAX  = 4096;
    localparam int IDX_W      = $clog2(VOCAB_MAX);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_VOCAB = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOPK  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BATCH = 2'd2;

    // -1e9 in Q32.16
    localparam logic signed [LOGIT_W-1:0] FLOOR = -48'sd65536000000000;

    localparam logic [ACC_W-1:0] ACC_MAX = ACC_W'(1) << CNT_W;

    typedef struct packed {
        logic signed [LOGIT_W-1:0] logit;
        logic [TGT_W-1:0]          target;
    } t_in_item;

    typedef struct packed {
        logic             row_hit;
        logic [CNT_W-1:0] correct_count;
        logic [CNT_W-1:0] rows_done;
        logic             batch_done;
        logic [ACC_W-1:0] accuracy_q16;
    } t_out_item;

    // entry handed from one cell to the next one down the list
    typedef struct packed {
        logic                      valid;
        logic                      ins;
        logic [IDX_W-1:0]          idx;
        logic signed [LOGIT_W-1:0] value;
    } t_cell_link;

    // status of a cell seen by the row-end check
    typedef struct packed {
        logic filled;
        logic match;
    } t_cell_stat;

endpackage

// ===== rtl/top_k_accuracy_counter.sv =====
// Takes one logit per cycle while busy is low; rows of 1 to 4096 logits stream back to back.
// A row's result strobes on o_valid through r_chk and then r_valid after its last logit is taken.
// A batch's last row holds busy high while the accuracy is divided
// out one quotient bit per cycle; its result strobes when the divider is done.
// Results cannot be stalled. Synchronous active-low reset clears the list, the
// counters and the registers (row length 4096, top_k 5, batch length 1).
module top_k_accuracy_counter
    import tkac_pkg::*;
#(
    parameter int TOPK_MAX = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  t_in_item              i_item,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_valid,
    output t_out_item             o_result
);

    localparam int KK_W = $clog2(TOPK_MAX + 1);

    logic [VOCAB_W-1:0] r_vocab;
    logic [TOPK_W-1:0]  r_topk;
    logic [CNT_W-1:0]   r_batch;
    logic [IDX_W-1:0]   r_elem;
    logic [TGT_W-1:0]   r_target;
    logic [CNT_W-1:0]   r_hits;
    logic [CNT_W-1:0]   r_rows;
    logic               r_chk;
    logic               r_valid;
    t_out_item          r_res;

    logic [VOCAB_W-1:0] vs_eff;
    logic [VOCAB_W-1:0] kk_wide;
    logic [KK_W-1:0]    kk;
    logic [CNT_W-1:0]   bs_eff;
    logic               accept;
    logic               first;
    logic               row_last;
    logic               above;
    logic               hit;
    logic               few;
    logic [CNT_W-1:0]   n_rows;
    logic [CNT_W-1:0]   n_hits;
    logic               bdone;
    logic               div_busy;
    logic               div_done;
    logic [ACC_W-1:0]   div_quot;

    t_cell_link         head;
    t_cell_link         w_link [TOPK_MAX];
    t_cell_stat         w_stat [TOPK_MAX];

    always_comb begin
        if (r_vocab == '0) begin
            vs_eff = VOCAB_W'(1);
        end else if (r_vocab > VOCAB_W'(VOCAB_MAX)) begin
            vs_eff = VOCAB_W'(VOCAB_MAX);
        end else begin
            vs_eff = r_vocab;
        end

        kk_wide = (r_topk == '0) ? VOCAB_W'(1) : VOCAB_W'(r_topk);
        if (kk_wide > VOCAB_W'(TOPK_MAX)) begin
            kk_wide = VOCAB_W'(TOPK_MAX);
        end
        if (kk_wide > vs_eff) begin
            kk_wide = vs_eff;
        end
        kk = kk_wide[KK_W-1:0];

        bs_eff = (r_batch == '0) ? CNT_W'(1) : r_batch;
    end

    assign accept   = start & ~busy;
    assign first    = (r_elem == '0);
    assign row_last = ({1'b0, r_elem} + VOCAB_W'(1)) >= vs_eff;
    assign above    = i_item.logit > FLOOR;

    assign head = '{valid: 1'b0, ins: 1'b0, idx: '0, value: '0};

    for (genvar g = 0; g < TOPK_MAX; g++) begin : g_cell
        tkac_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_step   (accept),
            .i_clr    (first),
            .i_load   (above),
            .i_key    (i_item.logit),
            .i_idx    (r_elem),
            .i_target (r_target),
            .i_prev   ((g == 0) ? head : w_link[(g == 0) ? 0 : g - 1]),
            .o_link   (w_link[g]),
            .o_stat   (w_stat[g])
        );
    end

    // row-end check runs on the list as it stands after the row's last beat
    always_comb begin
        hit = 1'b0;
        few = 1'b0;
        for (int i = 0; i < TOPK_MAX; i++) begin
            if (w_stat[i].match && (i < int'(kk))) begin
                hit = 1'b1;
            end
            if ((i + 1) == int'(kk)) begin
                few = ~w_stat[i].filled;
            end
        end
        if (few && (r_target == '0)) begin
            hit = 1'b1;
        end
        n_rows = r_rows + CNT_W'(1);
        n_hits = r_hits + CNT_W'(hit);
        bdone  = n_rows >= bs_eff;
    end

    assign busy = div_busy | (r_chk & bdone);

    tkac_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_chk & bdone),
        .i_hits    (n_hits),
        .i_divisor (bs_eff),
        .o_busy    (div_busy),
        .o_done    (div_done),
        .o_quot    (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vocab <= VOCAB_W'(4096);
            r_topk  <= TOPK_W'(5);
            r_batch <= CNT_W'(1);
            r_elem  <= '0;
            r_target <= '0;
            r_hits  <= '0;
            r_rows  <= '0;
            r_chk   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_VOCAB: r_vocab <= i_cfg_data[VOCAB_W-1:0];
                    CFG_TOPK:  r_topk  <= i_cfg_data[TOPK_W-1:0];
                    CFG_BATCH: r_batch <= i_cfg_data[CNT_W-1:0];
                    default:   ;
                endcase
            end

            r_chk <= accept & row_last;
            if (accept) begin
                r_elem <= row_last ? '0 : r_elem + IDX_W'(1);
                if (first) begin
                    r_target <= i_item.target;
                end
            end

            r_valid <= r_chk ? ~bdone : div_done;
            if (r_chk) begin
                r_rows  <= bdone ? '0 : n_rows;
                r_hits  <= bdone ? '0 : n_hits;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_chk) begin
            r_res.row_hit       <= hit;
            r_res.correct_count <= n_hits;
            r_res.rows_done     <= n_rows;
            r_res.batch_done    <= bdone;
            r_res.accuracy_q16  <= '0;
        end else if (div_done) begin
            r_res.accuracy_q16  <= div_quot;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_res;

endmodule

// ===== rtl/tkac_cell.sv =====
module tkac_cell
    import tkac_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_step,
    input  logic                      i_clr,
    input  logic                      i_load,
    input  logic signed [LOGIT_W-1:0] i_key,
    input  logic [IDX_W-1:0]          i_idx,
    input  logic [TGT_W-1:0]          i_target,
    input  t_cell_link                i_prev,
    output t_cell_link                o_link,
    output t_cell_stat                o_stat
);

    logic                      r_valid;
    logic signed [LOGIT_W-1:0] r_value;
    logic [IDX_W-1:0]          r_idx;
    logic                      eff_valid;
    logic                      ins;

    // a new row empties the list before this beat is placed
    assign eff_valid = r_valid & ~i_clr;
    // equal keys stay ahead: the older entry has the lower index
    assign ins       = ~eff_valid | (i_key > r_value);

    assign o_link = '{valid: eff_valid, ins: ins, idx: r_idx, value: r_value};
    assign o_stat = '{filled: r_valid,
                      match: r_valid & (i_target == r_idx)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_step) begin
            if (i_load && ins) begin
                r_valid <= i_prev.ins ? i_prev.valid : 1'b1;
            end else begin
                r_valid <= eff_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step && i_load && ins) begin
            if (i_prev.ins) begin
                r_value <= i_prev.value;
                r_idx   <= i_prev.idx;
            end else begin
                r_value <= i_key;
                r_idx   <= i_idx;
            end
        end
    end

endmodule

// ===== rtl/tkac_div.sv =====
module tkac_div
    import tkac_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [CNT_W-1:0]   i_hits,
    input  logic [CNT_W-1:0]   i_divisor,
    output logic               o_busy,
    output logic               o_done,
    output logic [ACC_W-1:0]   o_quot
);

    localparam int DIVD_W    = 2 * CNT_W;
    localparam int STEP_BITS = $clog2(DIVD_W);

    logic                 r_busy;
    logic                 r_done;
    logic [STEP_BITS-1:0] r_cnt;
    logic [CNT_W:0]       r_rem;
    logic [DIVD_W-1:0]    r_quo;
    logic [CNT_W-1:0]     r_div;
    logic [ACC_W-1:0]     r_res;

    logic [CNT_W:0]       rem_sh;
    logic                 ge;
    logic [CNT_W:0]       n_rem;
    logic [DIVD_W-1:0]    n_quo;

    // restoring division, one quotient bit per cycle
    always_comb begin
        rem_sh = {r_rem[CNT_W-1:0], r_quo[DIVD_W-1]};
        ge     = rem_sh >= {1'b0, r_div};
        n_rem  = ge ? rem_sh - {1'b0, r_div} : rem_sh;
        n_quo  = {r_quo[DIVD_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy & ~i_start & (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= STEP_BITS'(DIVD_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - STEP_BITS'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= {i_hits, CNT_W'(0)};
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
            if (r_cnt == '0) begin
                r_res <= (n_quo > DIVD_W'(ACC_MAX)) ? ACC_MAX : n_quo[ACC_W-1:0];
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_res;

endmodule
